FILE: rtl/mpf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mpf_pkg: shared types and constants
// Level geometry, operation and status codes, sequencer states.
// ---------------------------------------------------------------------------
package mpf_pkg;
  localparam int LowestLevel  = 7;
  localparam int LevelDepth   = 64;
  localparam int PayloadWidth = 32;
  localparam int Levels       = LowestLevel + 2;
  localparam int FailedLevel  = LowestLevel + 1;
  localparam int PtrW         = (LevelDepth > 1) ? $clog2(LevelDepth) : 1;
  localparam int CntW         = $clog2(LevelDepth + 1);
  localparam int LvlW         = $clog2(Levels);
  localparam int HintW        = (LowestLevel > 0) ? $clog2(LowestLevel + 1) : 1;
  localparam int AddrW        = $clog2(Levels * LevelDepth);

  typedef enum logic [1:0] {
    OP_PUT = 2'd0, OP_GET = 2'd1, OP_RECOVER = 2'd2, OP_NOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_GET_RD, S_SCAN, S_REC_RD, S_REC_WR, S_DONE
  } state_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic                    we;
    logic                    re;
    logic [AddrW-1:0]        waddr;
    logic [AddrW-1:0]        raddr;
    logic [PayloadWidth-1:0] wdata;
  } mem_req_t;
endpackage
`default_nettype wire

FILE: rtl/mpf_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mpf_in_if / mpf_out_if: valid/ready channels
// Input command channel and result channel.
// ---------------------------------------------------------------------------
interface mpf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] payload;
  logic [3:0]  level;
  modport source (output valid, operation, payload, level, input ready);
  modport sink   (input valid, operation, payload, level, output ready);
endinterface

interface mpf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_out;
  logic [1:0]  status;
  logic [9:0]  total_count;
  logic [2:0]  current_level;
  logic [6:0]  moved_count;
  modport source (output valid, data_out, status, total_count, current_level,
                  moved_count, input ready);
  modport sink   (input valid, data_out, status, total_count, current_level,
                  moved_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/mpf_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mpf_store: entry memory
// One write port and one registered read port over all levels.
// ---------------------------------------------------------------------------
module mpf_store
  import mpf_pkg::*;
(
  input  wire logic                    clk,
  input  wire mem_req_t                req,
  output      logic [PayloadWidth-1:0] rdata
);
  logic [PayloadWidth-1:0] mem [Levels*LevelDepth];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
  end

  // registered read
  always_ff @(posedge clk) begin
    if (req.re) rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/multilevel_priority_fifo_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// multilevel_priority_fifo_unit: strict-priority multi-level queue
//
// Commands arrive on cmd (operation, payload, level); one result beat per
// command leaves on rsp. One command is in work at a time; cmd.ready is low
// until its result beat is taken.
// Put and no-op go straight to the done state; get reads the head of the
// served level, then scans the levels for a new hint when that level
// drains; recover moves one word per read/write pair over the store's read
// and write ports, up to LevelDepth words.
// Per-level head/tail/count registers, the word total and the hint are
// cleared by reset; the memory is not, and a word is read only after it has
// been written. A stalled result holds the block in its done state with the
// beat stable until rsp.ready.
// ---------------------------------------------------------------------------
module multilevel_priority_fifo_unit
  import mpf_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  mpf_in_if.sink   cmd,
  mpf_out_if.source rsp
);
  state_t state, state_next;
  logic [PtrW-1:0] head [Levels];
  logic [PtrW-1:0] tail [Levels];
  logic [CntW-1:0] cnt  [Levels];
  logic [9:0]       total;
  logic [HintW-1:0] hint;
  logic [HintW-1:0] scan;
  logic [31:0] data_r;
  logic [1:0]  status_r;
  logic [6:0]  moved_r;
  logic [PayloadWidth-1:0] rdata;
  mem_req_t req;

  mpf_store u_store (.clk(clk), .req(req), .rdata(rdata));

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    nxt = (32'(p) + 1 >= LevelDepth) ? '0 : PtrW'(32'(p) + 1);
  endfunction

  function automatic logic [AddrW-1:0] addr(input logic [LvlW-1:0] lv,
                                            input logic [PtrW-1:0] p);
    addr = AddrW'(32'(lv) * LevelDepth + 32'(p));
  endfunction

  localparam logic [LvlW-1:0] LowL  = LvlW'(LowestLevel);
  localparam logic [LvlW-1:0] FailL = LvlW'(FailedLevel);

  logic [LvlW-1:0] hint_l;
  logic [LvlW-1:0] cmd_l;
  logic            cmd_lv_ok;
  assign hint_l    = LvlW'(hint);
  assign cmd_lv_ok = 32'(cmd.level) <= FailedLevel;
  assign cmd_l     = LvlW'(cmd.level);

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.data_out      = data_r;
  assign rsp.status        = status_r;
  assign rsp.total_count   = total;
  assign rsp.current_level = 3'(hint);
  assign rsp.moved_count   = moved_r;

  // next state and memory requests
  always_comb begin
    state_next = state;
    req = '0;
    req.raddr = addr(FailL, head[FailedLevel]);
    req.waddr = addr(cmd_l, tail[cmd_l]);
    req.wdata = PayloadWidth'(cmd.payload);
    case (state)
      S_IDLE: if (cmd.valid) begin
        case (op_t'(cmd.operation))
          OP_PUT: begin
            req.we = cmd_lv_ok && (32'(cnt[cmd_l]) < LevelDepth);
            state_next = S_DONE;
          end
          OP_GET: begin
            if (cnt[hint_l] != '0) begin
              req.re = 1'b1;
              req.raddr = addr(hint_l, head[hint_l]);
              state_next = S_GET_RD;
            end else state_next = S_DONE;
          end
          OP_RECOVER: state_next = S_REC_RD;
          default: state_next = S_DONE;
        endcase
      end
      S_GET_RD: state_next = (cnt[hint_l] == '0) ? S_SCAN : S_DONE;
      S_SCAN: if (cnt[LvlW'(scan)] != '0 || 32'(scan) >= LowestLevel)
        state_next = S_DONE;
      S_REC_RD: begin
        if (cnt[FailedLevel] != '0 && 32'(cnt[LowestLevel]) < LevelDepth) begin
          req.re = 1'b1;
          state_next = S_REC_WR;
        end else state_next = S_DONE;
      end
      S_REC_WR: begin
        req.we = 1'b1;
        req.waddr = addr(LowL, tail[LowestLevel]);
        req.wdata = rdata;
        state_next = S_REC_RD;
      end
      S_DONE: if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Levels; i++) begin
        head[i] <= '0; tail[i] <= '0; cnt[i] <= '0;
      end
      total <= '0;
      hint  <= HintW'(LowestLevel);
    end else begin
      case (state)
        S_IDLE: if (cmd.valid) begin
          data_r <= '0; moved_r <= '0;
          case (op_t'(cmd.operation))
            OP_PUT: if (cmd_lv_ok && 32'(cnt[cmd_l]) >= LevelDepth) begin
              status_r <= ST_FULL;
            end else begin
              status_r <= ST_OK;
              if (cmd_lv_ok) begin
                tail[cmd_l] <= nxt(tail[cmd_l]);
                cnt[cmd_l]  <= cnt[cmd_l] + 1'b1;
                if (32'(cmd.level) < 32'(hint)) hint <= HintW'(cmd.level);
                if (32'(cmd.level) <= LowestLevel) total <= total + 1'b1;
              end
            end
            OP_GET: if (cnt[hint_l] == '0) status_r <= ST_EMPTY;
            else begin
              status_r <= ST_OK;
              head[hint_l] <= nxt(head[hint_l]);
              cnt[hint_l]  <= cnt[hint_l] - 1'b1;
              total <= total - 1'b1;
              scan  <= hint;
            end
            default: status_r <= ST_OK;
          endcase
        end
        S_GET_RD: data_r <= 32'(rdata);
        S_SCAN: if (cnt[LvlW'(scan)] != '0 || 32'(scan) >= LowestLevel)
          hint <= scan;
        else scan <= scan + 1'b1;
        S_REC_RD: if (state_next == S_REC_WR) begin
          head[FailedLevel] <= nxt(head[FailedLevel]);
          cnt[FailedLevel]  <= cnt[FailedLevel] - 1'b1;
        end
        S_REC_WR: begin
          tail[LowestLevel] <= nxt(tail[LowestLevel]);
          cnt[LowestLevel]  <= cnt[LowestLevel] + 1'b1;
          total   <= total + 1'b1;
          moved_r <= moved_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // total never exceeds the normal-level capacity
  a_total: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= (LowestLevel + 1) * LevelDepth)
    else $error("word total out of range");
  // a get that reports empty leaves the total unchanged
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_EMPTY |-> $stable(total))
    else $error("empty get changed total");
  // recover never moves more than a level holds
  a_moved: assert property (@(posedge clk) disable iff (rst)
    32'(moved_r) <= LevelDepth)
    else $error("moved count overflow");
`endif
endmodule
`default_nettype wire
